>>> src/aes_cbc_pkg.sv
// Shared types, constants, tables and round functions of the AES-256 CBC core.
package aes_cbc_pkg;

   localparam int BLOCK_BITS = 128;
   localparam int ROUND_KEYS = 15;
   localparam logic [3:0] LAST_ROUND = 4'd14;
   localparam logic [4:0] FULL_COUNT = 5'd16;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_PAD   = 2'd1;
   localparam logic [1:0] ERR_SHORT = 2'd2;

   localparam logic [2:0] REG_KEY_0   = 3'd0;
   localparam logic [2:0] REG_KEY_1   = 3'd1;
   localparam logic [2:0] REG_KEY_2   = 3'd2;
   localparam logic [2:0] REG_KEY_3   = 3'd3;
   localparam logic [2:0] REG_IV_0    = 3'd4;
   localparam logic [2:0] REG_IV_1    = 3'd5;
   localparam logic [2:0] REG_DIR     = 3'd6;

   typedef struct packed {
      logic [BLOCK_BITS-1:0] data;
      logic [4:0]            count;      // clamped to 0..16
      logic                  last;
      logic                  enc;
      logic                  short_err;
   } item_type;

   localparam logic [7:0] FWD_SBOX [0:255] = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [0:255] = '{
 8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
 8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
 8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
 8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
 8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
 8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
 8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
 8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
 8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
 8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
 8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
 8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
 8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
 8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
 8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
 8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   localparam logic [7:0] RCON [0:6] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
   endfunction

   // byte i of the state sits at bits [127-8i -: 8]; column c holds bytes 4c..4c+3
   function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic enc);
      logic [127:0] t;
      int src;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = enc ? (((c + r) & 3) * 4 + r) : (((c - r + 4) & 3) * 4 + r);
            t[127-8*(c*4+r) -: 8] = enc ? FWD_SBOX[s[127-8*src -: 8]]
                                        : INV_SBOX[s[127-8*src -: 8]];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_cols(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127-32*c -: 8];
         a1 = s[119-32*c -: 8];
         a2 = s[111-32*c -: 8];
         a3 = s[103-32*c -: 8];
         t[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         t[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         t[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         t[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      return t;
   endfunction

   function automatic logic [127:0] inv_mix_cols(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0] a [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      logic [7:0] m9 [4];
      logic [7:0] mb [4];
      logic [7:0] md [4];
      logic [7:0] me [4];
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            a[k]  = s[127-32*c-8*k -: 8];
            x2[k] = xtime(a[k]);
            x4[k] = xtime(x2[k]);
            x8[k] = xtime(x4[k]);
            m9[k] = x8[k] ^ a[k];
            mb[k] = x8[k] ^ x2[k] ^ a[k];
            md[k] = x8[k] ^ x4[k] ^ a[k];
            me[k] = x8[k] ^ x4[k] ^ x2[k];
         end
         t[127-32*c -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
         t[119-32*c -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
         t[111-32*c -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
         t[103-32*c -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
      end
      return t;
   endfunction

endpackage

>>> src/aes_cbc_ifs.sv
// Channel interfaces of the AES-256 CBC core: request, response and register write.
interface aes_cbc_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] block_high;
   logic [63:0] block_low;
   logic [4:0]  byte_count;
   logic        is_last;
   modport source (output valid, block_high, block_low, byte_count, is_last, input ready);
   modport sink   (input valid, block_high, block_low, byte_count, is_last, output ready);
endinterface

interface aes_cbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_high;
   logic [63:0] result_low;
   logic [4:0]  result_bytes;
   logic        last_of_run;
   logic [1:0]  error_code;
   modport source (output valid, result_high, result_low, result_bytes, last_of_run,
                   error_code, input ready);
   modport sink   (input valid, result_high, result_low, result_bytes, last_of_run,
                   error_code, output ready);
endinterface

interface aes_cbc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> src/aes_cbc_front.sv
// Request intake: clamps the byte count and classifies each block before queueing.
module aes_cbc_front (
   aes_cbc_req_if.sink           req,
   input  logic                  direction,
   input  logic                  queue_full,
   output logic                  push,
   output aes_cbc_pkg::item_type item
);

   logic [4:0] count;

   assign count = (req.byte_count > aes_cbc_pkg::FULL_COUNT) ? aes_cbc_pkg::FULL_COUNT
                                                           : req.byte_count;

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   always_comb begin
      item.data      = {req.block_high, req.block_low};
      item.count     = count;
      item.last      = req.is_last;
      item.enc       = direction;
      // short block is legal only as the last block of an encrypt stream
      item.short_err = (count != aes_cbc_pkg::FULL_COUNT) && !(direction && req.is_last);
   end

endmodule

>>> src/aes_cbc_queue.sv
// Two-entry queue of classified blocks between intake and cipher engine.
module aes_cbc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  aes_cbc_pkg::item_type push_item,
   input  logic                  pop,
   output logic                  full,
   output logic                  not_empty,
   output aes_cbc_pkg::item_type head
);

   aes_cbc_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> src/aes_cbc_back.sv
// Cipher engine: key expansion, one AES round per cycle, CBC chaining and padding.
module aes_cbc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  aes_cbc_pkg::item_type item,
   output logic                  pop,
   input  logic [255:0]          key,
   input  logic [127:0]          iv,
   aes_cbc_rsp_if.source         rsp
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXPAND = 3'd1;
   localparam logic [2:0] ST_LOAD   = 3'd2;
   localparam logic [2:0] ST_INIT   = 3'd3;
   localparam logic [2:0] ST_ROUND  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;
   localparam logic [2:0] ST_ERROR  = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [3:0]            cnt_ff, cnt_in;
   aes_cbc_pkg::item_type item_ff, item_in;
   logic                  extra_ff, extra_in;
   logic                  active_ff, active_in;
   logic [127:0]          chain_ff, chain_in;
   logic [127:0]          s_ff, s_in;
   logic [127:0]          prev2_ff, prev2_in;
   logic [127:0]          prev1_ff, prev1_in;
   logic [127:0]          rk_ff;
   logic [127:0]          rk_mem [aes_cbc_pkg::ROUND_KEYS];
   logic                  out_valid_ff, out_valid_in;
   logic [127:0]          out_data_ff, out_data_in;
   logic [4:0]            out_bytes_ff, out_bytes_in;
   logic                  out_last_ff, out_last_in;
   logic [1:0]            out_err_ff, out_err_in;

   logic         out_free;
   logic         rk_we;
   logic [127:0] rk_wdata;
   logic [127:0] next_rk;
   logic [3:0]   step;
   logic [3:0]   rd_addr;

   assign out_free = !out_valid_ff || rsp.ready;
   assign pop      = (state_ff == ST_IDLE) && item_valid;

   // next round key from the two previous ones
   always_comb begin
      logic [31:0] t;
      logic [31:0] n0, n1, n2, n3;
      logic [31:0] w;
      w = prev1_ff[31:0];
      if (!cnt_ff[0]) begin
         t = aes_cbc_pkg::sub_word({w[23:0], w[31:24]})
             ^ {aes_cbc_pkg::RCON[cnt_ff[3:1] - 3'd1], 24'h0};
      end else begin
         t = aes_cbc_pkg::sub_word(w);
      end
      n0 = prev2_ff[127:96] ^ t;
      n1 = prev2_ff[95:64] ^ n0;
      n2 = prev2_ff[63:32] ^ n1;
      n3 = prev2_ff[31:0] ^ n2;
      next_rk = {n0, n1, n2, n3};
   end

   // round-key read is registered, so its address is issued in the state before the one that uses it
   always_comb begin
      unique case (state_ff)
         ST_LOAD:  step = 4'd0;
         ST_INIT:  step = 4'd1;
         ST_ROUND: step = (cnt_ff == aes_cbc_pkg::LAST_ROUND) ? cnt_ff : cnt_ff + 4'd1;
         default:  step = 4'd0;
      endcase
      rd_addr = item_ff.enc ? step : aes_cbc_pkg::LAST_ROUND - step;
   end

   always_comb begin
      logic [127:0] blk;
      logic [127:0] t;
      logic [127:0] p;
      logic [7:0]   pad;
      logic         ok;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      item_in      = item_ff;
      extra_in     = extra_ff;
      active_in    = active_ff;
      chain_in     = chain_ff;
      s_in         = s_ff;
      prev2_in     = prev2_ff;
      prev1_in     = prev1_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_data_in  = out_data_ff;
      out_bytes_in = out_bytes_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;
      rk_we        = 1'b0;
      rk_wdata     = next_rk;
      blk          = '0;
      t            = '0;
      p            = '0;
      pad          = '0;
      ok           = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_in  = item;
               extra_in = 1'b0;
               if (item.short_err) begin
                  state_in = ST_ERROR;
               end else if (!active_ff) begin
                  state_in  = ST_EXPAND;
                  cnt_in    = 4'd0;
                  chain_in  = iv;
                  active_in = 1'b1;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_EXPAND: begin
            rk_we = 1'b1;
            if (cnt_ff == 4'd0) begin
               rk_wdata = key[255:128];
            end else if (cnt_ff == 4'd1) begin
               rk_wdata = key[127:0];
            end
            prev2_in = prev1_ff;
            prev1_in = rk_wdata;
            cnt_in   = cnt_ff + 4'd1;
            if (cnt_ff == aes_cbc_pkg::LAST_ROUND) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_INIT;
         end
         ST_INIT: begin
            if (item_ff.enc) begin
               for (int i = 0; i < 16; i++) begin
                  if (extra_ff) begin
                     blk[127-8*i -: 8] = 8'h10;
                  end else if (5'(i) < item_ff.count) begin
                     blk[127-8*i -: 8] = item_ff.data[127-8*i -: 8];
                  end else begin
                     blk[127-8*i -: 8] = {3'b000, aes_cbc_pkg::FULL_COUNT - item_ff.count};
                  end
               end
               s_in = blk ^ chain_ff ^ rk_ff;
            end else begin
               s_in = item_ff.data ^ rk_ff;
            end
            cnt_in   = 4'd1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (item_ff.enc) begin
               t    = aes_cbc_pkg::sub_shift(s_ff, 1'b1);
               s_in = ((cnt_ff == aes_cbc_pkg::LAST_ROUND) ? t : aes_cbc_pkg::mix_cols(t))
                      ^ rk_ff;
            end else begin
               t    = aes_cbc_pkg::sub_shift(s_ff, 1'b0) ^ rk_ff;
               s_in = (cnt_ff == aes_cbc_pkg::LAST_ROUND) ? t : aes_cbc_pkg::inv_mix_cols(t);
            end
            if (cnt_ff == aes_cbc_pkg::LAST_ROUND) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_err_in   = aes_cbc_pkg::ERR_NONE;
               if (item_ff.enc) begin
                  chain_in     = s_ff;
                  out_data_in  = s_ff;
                  out_bytes_in = aes_cbc_pkg::FULL_COUNT;
                  out_last_in  = extra_ff ||
                                 (item_ff.last && item_ff.count != aes_cbc_pkg::FULL_COUNT);
                  if (item_ff.last && !extra_ff &&
                      item_ff.count == aes_cbc_pkg::FULL_COUNT) begin
                     // full last block: follow with a whole pad block
                     extra_in = 1'b1;
                     state_in = ST_LOAD;
                  end else begin
                     if (item_ff.last) begin
                        active_in = 1'b0;
                     end
                     state_in = ST_IDLE;
                  end
               end else begin
                  p        = s_ff ^ chain_ff;
                  chain_in = item_ff.data;
                  state_in = ST_IDLE;
                  if (!item_ff.last) begin
                     out_data_in  = p;
                     out_bytes_in = aes_cbc_pkg::FULL_COUNT;
                     out_last_in  = 1'b0;
                  end else begin
                     active_in = 1'b0;
                     pad       = p[7:0];
                     ok        = (pad >= 8'd1) && (pad <= 8'd16);
                     for (int i = 1; i < 16; i++) begin
                        if ((8'(i) < pad) && (p[8*i+7 -: 8] != pad)) begin
                           ok = 1'b0;
                        end
                     end
                     out_last_in = 1'b1;
                     if (ok) begin
                        for (int i = 0; i < 16; i++) begin
                           if (8'(i) + pad >= 8'd16) begin
                              p[127-8*i -: 8] = 8'h00;
                           end
                        end
                        out_data_in  = p;
                        out_bytes_in = aes_cbc_pkg::FULL_COUNT - pad[4:0];
                     end else begin
                        out_data_in  = '0;
                        out_bytes_in = 5'd0;
                        out_err_in   = aes_cbc_pkg::ERR_PAD;
                     end
                  end
               end
            end
         end
         ST_ERROR: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = '0;
               out_bytes_in = 5'd0;
               out_last_in  = 1'b1;
               out_err_in   = aes_cbc_pkg::ERR_SHORT;
               active_in    = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         extra_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
         chain_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         extra_ff     <= extra_in;
         out_valid_ff <= out_valid_in;
         chain_ff     <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      item_ff      <= item_in;
      s_ff         <= s_in;
      prev2_ff     <= prev2_in;
      prev1_ff     <= prev1_in;
      out_data_ff  <= out_data_in;
      out_bytes_ff <= out_bytes_in;
      out_last_ff  <= out_last_in;
      out_err_ff   <= out_err_in;
   end

   always_ff @(posedge clock) begin
      if (rk_we) begin
         rk_mem[cnt_ff] <= rk_wdata;
      end
      rk_ff <= rk_mem[rd_addr];
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.result_high  = out_data_ff[127:64];
   assign rsp.result_low   = out_data_ff[63:0];
   assign rsp.result_bytes = out_bytes_ff;
   assign rsp.last_of_run  = out_last_ff;
   assign rsp.error_code   = out_err_ff;

endmodule

>>> src/aes256_cbc_cipher_core.sv
// Top level of the AES-256 CBC cipher core with PKCS7 padding.
//
// Usage:
//  - csr: register writes (index 0..3 key, 4..5 IV, 6 direction), always ready.
//    Write only while the core is idle; key and IV take effect at the next
//    stream start, direction is sampled when a block is transferred in.
//  - req: 16-byte blocks with a byte count and a last mark. Blocks enter a
//    two-entry queue, so req stays ready until the queue fills.
//  - rsp: one result per block; a full last encrypt block yields a second,
//    whole-pad result. Short or padding errors give one zeroed result.
// Timing: a block passes the engine in pick-up, load, whitening, 14 rounds
//  at one round per cycle from the round-key memory, and finish. The
//  whole-pad block skips the pick-up. The first block of a stream adds key
//  expansion of all 15 round keys, one round key per cycle. CBC chaining
//  keeps the engine sequential: a new block is picked up only after the
//  last one finishes.
// Reset: synchronous; clears the queue, the stream flag and the output
//  register; key, IV clear to zero and direction resets to encrypt.
// Stall: a waiting result is held in the output register; the engine stops
//  at its finish step until rsp takes it, and req stops once the queue fills.
module aes256_cbc_cipher_core (
   input  logic          clock,
   input  logic          reset,
   aes_cbc_req_if.sink   req,
   aes_cbc_rsp_if.source rsp,
   aes_cbc_csr_if.sink   csr
);

   logic [63:0] key_ff [4];
   logic [63:0] iv_ff  [2];
   logic        dir_ff;

   logic                  push;
   logic                  pop;
   logic                  queue_full;
   logic                  queue_valid;
   aes_cbc_pkg::item_type push_item;
   aes_cbc_pkg::item_type head_item;

   // register file; writes to undefined indexes are dropped
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff[0] <= '0;
         key_ff[1] <= '0;
         key_ff[2] <= '0;
         key_ff[3] <= '0;
         iv_ff[0]  <= '0;
         iv_ff[1]  <= '0;
         dir_ff    <= 1'b1;
      end else if (csr.valid) begin
         unique case (csr.index)
            aes_cbc_pkg::REG_KEY_0: key_ff[0] <= csr.data;
            aes_cbc_pkg::REG_KEY_1: key_ff[1] <= csr.data;
            aes_cbc_pkg::REG_KEY_2: key_ff[2] <= csr.data;
            aes_cbc_pkg::REG_KEY_3: key_ff[3] <= csr.data;
            aes_cbc_pkg::REG_IV_0:  iv_ff[0]  <= csr.data;
            aes_cbc_pkg::REG_IV_1:  iv_ff[1]  <= csr.data;
            aes_cbc_pkg::REG_DIR:   dir_ff    <= csr.data[0];
            default: ;
         endcase
      end
   end

   // intake classifies each transfer against the current direction
   aes_cbc_front u_front (
      .req        (req),
      .direction  (dir_ff),
      .queue_full (queue_full),
      .push       (push),
      .item       (push_item)
   );

   aes_cbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_valid),
      .head      (head_item)
   );

   aes_cbc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item       (head_item),
      .pop        (pop),
      .key        ({key_ff[0], key_ff[1], key_ff[2], key_ff[3]}),
      .iv         ({iv_ff[0], iv_ff[1]}),
      .rsp        (rsp)
   );

endmodule

>>> verif/aes256_cbc_cipher_core_test.sv
// Self-checking testbench of the AES-256 CBC cipher core with PKCS7 padding.
`timescale 1ns / 1ps
module aes256_cbc_cipher_core_test;

   localparam int CLOCK_PERIOD = 12;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int ITEM_TARGET  = 1950;
   // wait after the last response that covers a block plus key expansion at stream start
   localparam int SETTLE_CYCLES = 60;

   typedef struct {
      bit [63:0] high;
      bit [63:0] low;
      bit [4:0]  nbytes;
      bit        fin;
      bit [1:0]  err;
   } cipher_result_type;

   typedef enum bit {ROW_BLOCK, ROW_CSR} row_kind_type;

   // For register rows the index is in csr_index and the value in data_high.
   // Rows with short_known set carry the obvious short-block error response.
   typedef struct {
      row_kind_type kind;
      bit [2:0]     csr_index;
      bit [63:0]    data_high;
      bit [63:0]    data_low;
      bit [4:0]     count;
      bit           last;
      bit           short_known;
   } stim_row_type;

   localparam bit [63:0] ONES = 64'hffff_ffff_ffff_ffff;

   logic clock;
   logic reset;

   aes_cbc_req_if req ();
   aes_cbc_rsp_if rsp ();
   aes_cbc_csr_if csr ();

   aes256_cbc_cipher_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   // register shadow and cipher state as the core should hold them
   bit [63:0]  cfg_key [4];
   bit [63:0]  cfg_iv [2];
   bit         cfg_encrypt;
   bit [31:0]  round_words [60];
   bit [127:0] chain_block;
   bit         stream_open;

   cipher_result_type pending_results [$];
   int  mismatch_count = 0;
   int  blocks_sent;
   int  cycle_count = 0;
   int  sender_idle_pct;
   int  receiver_stall_pct;

   // ---------------------------------------------------------------
   // AES arithmetic; byte i of a block sits at [127-8i -: 8]
   // ---------------------------------------------------------------
   function automatic bit [7:0] gf_times(bit [7:0] a, bit [7:0] b);
      bit [7:0] acc;
      acc = 0;
      for (int i = 0; i < 8; i++) begin
         if (b[0]) acc ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
         b = b >> 1;
      end
      return acc;
   endfunction

   function automatic bit [31:0] sbox_word(bit [31:0] w);
      return {aes_cbc_pkg::FWD_SBOX[w[31:24]], aes_cbc_pkg::FWD_SBOX[w[23:16]],
              aes_cbc_pkg::FWD_SBOX[w[15:8]], aes_cbc_pkg::FWD_SBOX[w[7:0]]};
   endfunction

   task automatic expand_schedule(input bit [63:0] key [4], output bit [31:0] w [60]);
      bit [31:0] t;
      for (int i = 0; i < 8; i++)
         w[i] = i[0] ? key[i >> 1][31:0] : key[i >> 1][63:32];
      for (int i = 8; i < 60; i++) begin
         t = w[i-1];
         if ((i & 7) == 0)
            t = sbox_word({t[23:0], t[31:24]}) ^ {aes_cbc_pkg::RCON[(i >> 3) - 1], 24'h0};
         else if ((i & 7) == 4)
            t = sbox_word(t);
         w[i] = w[i-8] ^ t;
      end
   endtask

   function automatic bit [127:0] add_round(bit [127:0] s, bit [31:0] w [60], int round);
      for (int c = 0; c < 4; c++)
         s[127-32*c -: 32] ^= w[round*4 + c];
      return s;
   endfunction

   function automatic bit [127:0] sub_rotate(bit [127:0] s, bit forward);
      bit [127:0] t;
      int src;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            src = forward ? ((c + r) & 3) * 4 + r : ((c - r + 4) & 3) * 4 + r;
            t[127-8*(c*4+r) -: 8] = forward ? aes_cbc_pkg::FWD_SBOX[s[127-8*src -: 8]]
                                            : aes_cbc_pkg::INV_SBOX[s[127-8*src -: 8]];
         end
      return t;
   endfunction

   function automatic bit [127:0] column_mix(bit [127:0] s, bit forward);
      bit [7:0] m [4];
      bit [7:0] a [4];
      bit [127:0] t;
      if (forward) m = '{8'h02, 8'h03, 8'h01, 8'h01};
      else         m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) a[k] = s[127-32*c-8*k -: 8];
         for (int r = 0; r < 4; r++)
            t[127-32*c-8*r -: 8] = gf_times(a[0], m[(4-r) & 3]) ^ gf_times(a[1], m[(5-r) & 3])
                                 ^ gf_times(a[2], m[(6-r) & 3]) ^ gf_times(a[3], m[(7-r) & 3]);
      end
      return t;
   endfunction

   function automatic bit [127:0] aes_encrypt(bit [127:0] s, bit [31:0] w [60]);
      s = add_round(s, w, 0);
      for (int round = 1; round < 14; round++)
         s = add_round(column_mix(sub_rotate(s, 1), 1), w, round);
      return add_round(sub_rotate(s, 1), w, 14);
   endfunction

   function automatic bit [127:0] aes_decrypt(bit [127:0] s, bit [31:0] w [60]);
      s = add_round(s, w, 14);
      for (int round = 13; round >= 1; round--)
         s = column_mix(add_round(sub_rotate(s, 0), w, round), 0);
      return add_round(sub_rotate(s, 0), w, 0);
   endfunction

   // ---------------------------------------------------------------
   // Block predictor: pushes the responses one accepted block causes
   // ---------------------------------------------------------------
   function automatic void push_result(bit [127:0] b, bit [4:0] n, bit fin, bit [1:0] err);
      cipher_result_type r;
      r.high = b[127:64];
      r.low = b[63:0];
      r.nbytes = n;
      r.fin = fin;
      r.err = err;
      pending_results.push_back(r);
   endfunction

   task automatic predict_block(input bit [127:0] data, input bit [4:0] raw_count,
                                input bit last);
      bit [4:0]   n;
      bit [127:0] b;
      bit [7:0]   pad;
      bit         pad_ok;
      n = (raw_count > aes_cbc_pkg::FULL_COUNT) ? aes_cbc_pkg::FULL_COUNT : raw_count;
      if (!stream_open) begin
         expand_schedule(cfg_key, round_words);
         chain_block = {cfg_iv[0], cfg_iv[1]};
         stream_open = 1;
      end
      // short block: allowed only as the last block of an encrypt message
      if (n < aes_cbc_pkg::FULL_COUNT && !(cfg_encrypt && last)) begin
         push_result('0, 0, 1, aes_cbc_pkg::ERR_SHORT);
         stream_open = 0;
         return;
      end
      b = data;
      if (cfg_encrypt) begin
         for (int i = n; i < 16; i++) b[127-8*i -: 8] = 8'd16 - n;
         b = aes_encrypt(b ^ chain_block, round_words);
         chain_block = b;
         push_result(b, aes_cbc_pkg::FULL_COUNT, last && n < aes_cbc_pkg::FULL_COUNT,
                     aes_cbc_pkg::ERR_NONE);
         if (!last) return;
         stream_open = 0;
         if (n < aes_cbc_pkg::FULL_COUNT) return;
         // full last block: a whole pad block follows
         b = aes_encrypt({16{8'h10}} ^ chain_block, round_words);
         chain_block = b;
         push_result(b, aes_cbc_pkg::FULL_COUNT, 1, aes_cbc_pkg::ERR_NONE);
         return;
      end
      b = aes_decrypt(data, round_words) ^ chain_block;
      chain_block = data;
      if (!last) begin
         push_result(b, aes_cbc_pkg::FULL_COUNT, 0, aes_cbc_pkg::ERR_NONE);
         return;
      end
      stream_open = 0;
      pad = b[7:0];
      pad_ok = pad >= 1 && pad <= 16;
      for (int i = 1; pad_ok && i < pad; i++)
         if (b[127-8*(15-i) -: 8] != pad) pad_ok = 0;
      if (!pad_ok) begin
         push_result('0, 0, 1, aes_cbc_pkg::ERR_PAD);
         return;
      end
      for (int i = 16 - pad; i < 16; i++) b[127-8*i -: 8] = 8'h00;
      push_result(b, 5'(16 - pad), 1, aes_cbc_pkg::ERR_NONE);
   endtask

   // ---------------------------------------------------------------
   // Clock, cycle limit
   // ---------------------------------------------------------------
   initial begin
      clock = 0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Response side: random stalls at the falling edge, check at rising
   // ---------------------------------------------------------------
   always @(negedge clock)
      rsp.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);

   always @(posedge clock) begin
      cipher_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response high=%h low=%h bytes=%0d last=%b err=%0d",
                     $time, rsp.result_high, rsp.result_low, rsp.result_bytes,
                     rsp.last_of_run, rsp.error_code);
         end else begin
            want = pending_results.pop_front();
            if (rsp.result_high !== want.high || rsp.result_low !== want.low ||
                rsp.result_bytes !== want.nbytes || rsp.last_of_run !== want.fin ||
                rsp.error_code !== want.err) begin
               mismatch_count++;
               $display("%0t: mismatch expected high=%h low=%h bytes=%0d last=%b err=%0d",
                        $time, want.high, want.low, want.nbytes, want.fin, want.err);
               $display("%0t:          actual   high=%h low=%h bytes=%0d last=%b err=%0d",
                        $time, rsp.result_high, rsp.result_low, rsp.result_bytes,
                        rsp.last_of_run, rsp.error_code);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Request and register drivers; every task starts and ends at negedge
   // ---------------------------------------------------------------
   task automatic send_block(input bit [127:0] data, input bit [4:0] count, input bit last,
                             input bit short_known);
      int queued;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req.valid = 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req.block_high = data[127:64];
      req.block_low  = data[63:0];
      req.byte_count = count;
      req.is_last    = last;
      req.valid      = 1;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      // transfer taken at this edge
      queued = pending_results.size();
      predict_block(data, count, last);
      if (short_known) begin
         while (pending_results.size() > queued) void'(pending_results.pop_back());
         push_result('0, 0, 1, aes_cbc_pkg::ERR_SHORT);
      end
      blocks_sent++;
      @(negedge clock);
   endtask

   // waits out every response, then the engine's own tail
   task automatic drain_core();
      req.valid = 0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input bit [2:0] index, input bit [63:0] value);
      csr.index = index;
      csr.data  = value;
      csr.valid = 1;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      case (index)
         aes_cbc_pkg::REG_KEY_0: cfg_key[0] = value;
         aes_cbc_pkg::REG_KEY_1: cfg_key[1] = value;
         aes_cbc_pkg::REG_KEY_2: cfg_key[2] = value;
         aes_cbc_pkg::REG_KEY_3: cfg_key[3] = value;
         aes_cbc_pkg::REG_IV_0:  cfg_iv[0] = value;
         aes_cbc_pkg::REG_IV_1:  cfg_iv[1] = value;
         aes_cbc_pkg::REG_DIR:   cfg_encrypt = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr.valid = 0;
   endtask

   function automatic bit [63:0] pick_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return ONES;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic bit [127:0] random_block();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   // full count, now and then an oversized one that acts as 16
   function automatic bit [4:0] full_count();
      return ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31)) : aes_cbc_pkg::FULL_COUNT;
   endfunction

   // well-formed encrypt message, with an occasional short middle block
   task automatic send_encrypt_message();
      int nblk;
      bit [4:0] cnt;
      nblk = $urandom_range(1, 5);
      for (int i = 0; i < nblk; i++) begin
         if (i == nblk - 1)
            cnt = ($urandom_range(0, 3) == 0) ? full_count() : 5'($urandom_range(0, 16));
         else if ($urandom_range(0, 19) == 0)
            cnt = 5'($urandom_range(0, 15));
         else
            cnt = full_count();
         send_block(random_block(), cnt, i == nblk - 1, 0);
      end
   endtask

   // ciphertext of a padded message under the current key and IV; the last
   // plaintext block may carry a broken pad so the check is exercised
   task automatic send_decrypt_message();
      bit [31:0]  sched [60];
      bit [127:0] plain [$];
      bit [127:0] chain;
      bit [127:0] b;
      int nblk, pad, flaw, pos;
      nblk = $urandom_range(1, 4);
      for (int i = 0; i < nblk; i++) plain.push_back(random_block());
      pad = $urandom_range(1, 16);
      b = plain[nblk-1];
      for (int i = 16 - pad; i < 16; i++) b[127-8*i -: 8] = 8'(pad);
      flaw = $urandom_range(0, 9);
      case (flaw)
         0: b[7:0] = 8'h00;
         1: b[7:0] = 8'($urandom_range(17, 255));
         2: if (pad > 1) begin
               pos = $urandom_range(16 - pad, 14);
               b[127-8*pos -: 8] ^= 8'($urandom_range(1, 255));
            end
         default: ;
      endcase
      plain[nblk-1] = b;
      expand_schedule(cfg_key, sched);
      chain = {cfg_iv[0], cfg_iv[1]};
      for (int i = 0; i < nblk; i++) begin
         chain = aes_encrypt(plain[i] ^ chain, sched);
         b = chain;
         if (flaw == 3 && i == nblk - 1) b[127-8*$urandom_range(0, 15) -: 8] ^= 8'h5a;
         if (flaw == 4 && i == 0 && $urandom_range(0, 1))
            send_block(b, 5'($urandom_range(0, 15)), i == nblk - 1, 0);
         else
            send_block(b, full_count(), i == nblk - 1, 0);
      end
   endtask

   // ---------------------------------------------------------------
   // Directed rows: reset values, extremes, every special case
   // ---------------------------------------------------------------
   stim_row_type directed [] = '{
      '{ROW_BLOCK, aes_cbc_pkg::REG_KEY_0, 64'h0, 64'h0, 5'd16, 1'b0, 1'b0},
      '{ROW_BLOCK, aes_cbc_pkg::REG_KEY_0, ONES, ONES, 5'd16, 1'b1, 1'b0},
      '{ROW_BLOCK, aes_cbc_pkg::REG_KEY_0, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff,
        5'd0, 1'b1, 1'b0},
      '{ROW_BLOCK, aes_cbc_pkg::REG_KEY_0, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
        5'd31, 1'b1, 1'b0},
      '{ROW_BLOCK, aes_cbc_pkg::REG_KEY_0, ONES, 64'h0, 5'd5, 1'b0, 1'b1},
      '{ROW_BLOCK, aes_cbc_pkg::REG_KEY_0, ONES, ONES, 5'd15, 1'b1, 1'b0},
      '{ROW_BLOCK, aes_cbc_pkg::REG_KEY_0, ONES, ONES, 5'd1, 1'b1, 1'b0},
      '{ROW_BLOCK, aes_cbc_pkg::REG_KEY_0, ONES, ONES, 5'd0, 1'b0, 1'b1},
      '{ROW_CSR, aes_cbc_pkg::REG_KEY_0, ONES, 64'h0, 5'd0, 1'b0, 1'b0},
      '{ROW_CSR, aes_cbc_pkg::REG_KEY_1, ONES, 64'h0, 5'd0, 1'b0, 1'b0},
      '{ROW_CSR, aes_cbc_pkg::REG_KEY_2, ONES, 64'h0, 5'd0, 1'b0, 1'b0},
      '{ROW_CSR, aes_cbc_pkg::REG_KEY_3, ONES, 64'h0, 5'd0, 1'b0, 1'b0},
      '{ROW_CSR, aes_cbc_pkg::REG_IV_0, ONES, 64'h0, 5'd0, 1'b0, 1'b0},
      '{ROW_CSR, aes_cbc_pkg::REG_IV_1, ONES, 64'h0, 5'd0, 1'b0, 1'b0},
      '{ROW_BLOCK, aes_cbc_pkg::REG_KEY_0, 64'h0, 64'h0, 5'd16, 1'b0, 1'b0},
      '{ROW_BLOCK, aes_cbc_pkg::REG_KEY_0, 64'h0, ONES, 5'd16, 1'b1, 1'b0},
      '{ROW_CSR, aes_cbc_pkg::REG_DIR, 64'h0, 64'h0, 5'd0, 1'b0, 1'b0},
      '{ROW_BLOCK, aes_cbc_pkg::REG_KEY_0, ONES, ONES, 5'd8, 1'b1, 1'b1},
      '{ROW_BLOCK, aes_cbc_pkg::REG_KEY_0, ONES, ONES, 5'd16, 1'b0, 1'b0},
      '{ROW_BLOCK, aes_cbc_pkg::REG_KEY_0, 64'h0, 64'h0, 5'd16, 1'b1, 1'b0},
      '{ROW_BLOCK, aes_cbc_pkg::REG_KEY_0, 64'h0, 64'h0, 5'd20, 1'b1, 1'b0},
      '{ROW_BLOCK, aes_cbc_pkg::REG_KEY_0, ONES, ONES, 5'd15, 1'b0, 1'b1},
      '{ROW_CSR, aes_cbc_pkg::REG_DIR, 64'h1, 64'h0, 5'd0, 1'b0, 1'b0}
   };

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      int phase;
      reset = 1;
      req.valid = 0;
      req.block_high = '0;
      req.block_low = '0;
      req.byte_count = '0;
      req.is_last = 0;
      csr.valid = 0;
      csr.index = '0;
      csr.data = '0;
      cfg_key = '{default: '0};
      cfg_iv = '{default: '0};
      cfg_encrypt = 1;
      stream_open = 0;
      chain_block = '0;
      blocks_sent = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR) begin
            drain_core();
            write_register(directed[i].csr_index, directed[i].data_high);
         end else begin
            send_block({directed[i].data_high, directed[i].data_low}, directed[i].count,
                       directed[i].last, directed[i].short_known);
         end
      end

      // Random phases: each starts idle, reprograms every register, then
      // runs messages under one idling pattern. The drain at the head of
      // each phase holds the sender until all responses are back.
      phase = 0;
      while (blocks_sent < ITEM_TARGET) begin
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 53; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 53; end
            default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
         endcase
         drain_core();
         write_register(aes_cbc_pkg::REG_KEY_0, pick_word());
         write_register(aes_cbc_pkg::REG_KEY_1, pick_word());
         write_register(aes_cbc_pkg::REG_KEY_2, pick_word());
         write_register(aes_cbc_pkg::REG_KEY_3, pick_word());
         write_register(aes_cbc_pkg::REG_IV_0, pick_word());
         write_register(aes_cbc_pkg::REG_IV_1, pick_word());
         write_register(aes_cbc_pkg::REG_DIR, 64'($urandom_range(0, 1)));
         repeat ($urandom_range(4, 10)) begin
            if ($urandom_range(0, 19) == 0)
               send_block(random_block(), 5'($urandom_range(0, 31)), 1'($urandom), 0);
            else if (cfg_encrypt)
               send_encrypt_message();
            else
               send_decrypt_message();
         end
         phase++;
      end

      req.valid = 0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

>>> files.f
src/aes_cbc_pkg.sv
src/aes_cbc_ifs.sv
src/aes_cbc_front.sv
src/aes_cbc_queue.sv
src/aes_cbc_back.sv
src/aes256_cbc_cipher_core.sv
verif/aes256_cbc_cipher_core_test.sv
